[hdl/gnas_pkg.sv]
// shared types and constants of the grid neighbor average smoother
package gnas_pkg;

  localparam int CMD_W    = 2;
  localparam int COORD_W  = 6;
  localparam int HEIGHT_W = 16;
  localparam int PASS_W   = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE  = 2'd0,
    CMD_SMOOTH = 2'd1,
    CMD_READ   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CALC,
    ST_CALC_END,
    ST_COPY,
    ST_COPY_END
  } gnas_state_e;

  // order in which the four neighbors of a point are fetched
  typedef enum logic [1:0] {
    NB_NORTH = 2'd0,
    NB_SOUTH = 2'd1,
    NB_WEST  = 2'd2,
    NB_EAST  = 2'd3
  } nbr_e;

  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mean_ctl_t;

endpackage

[hdl/gnas_ram.sv]
// single write port, single registered read port memory
module gnas_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/gnas_mean_unit.sv]
// shared accumulator that sums four neighbor reads and writes the floored mean
module gnas_mean_unit #(
  parameter int HEIGHT_WIDTH = 16,
  parameter int ADDR_WIDTH   = 12
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  gnas_pkg::mean_ctl_t            ctl_i,
  input  logic [ADDR_WIDTH-1:0]          addr_i,
  input  logic signed [HEIGHT_WIDTH-1:0] rdata_i,
  output logic                           we_o,
  output logic [ADDR_WIDTH-1:0]          waddr_o,
  output logic [HEIGHT_WIDTH-1:0]        wdata_o
);
  import gnas_pkg::*;

  localparam int SUM_W = HEIGHT_WIDTH + 2;

  mean_ctl_t               ctl_q;
  logic [ADDR_WIDTH-1:0]   addr_q;
  logic signed [SUM_W-1:0] acc_q, acc_d;
  logic signed [SUM_W-1:0] sum;

  // ctl and address are delayed to line up with the registered read data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q <= addr_i;
    acc_q  <= acc_d;
  end

  always_comb begin
    if (ctl_q.first) begin
      sum = SUM_W'(rdata_i);
    end else begin
      sum = acc_q + SUM_W'(rdata_i);
    end
    acc_d   = ctl_q.valid ? sum : acc_q;
    we_o    = ctl_q.valid && ctl_q.last;
    waddr_o = addr_q;
    wdata_o = HEIGHT_WIDTH'(sum >>> 2);
  end

endmodule

[hdl/gnas_ctrl.sv]
// sequencer: command decode, clearing sweep, pass walk and copy back
module gnas_ctrl #(
  parameter int GRID_SIZE    = 64,
  parameter int HEIGHT_WIDTH = 16
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     start_i,
  output logic                                     busy_o,
  input  logic [gnas_pkg::CMD_W-1:0]               command_i,
  input  logic [gnas_pkg::COORD_W-1:0]             row_i,
  input  logic [gnas_pkg::COORD_W-1:0]             col_i,
  input  logic signed [gnas_pkg::HEIGHT_W-1:0]     height_in_i,
  input  logic [gnas_pkg::PASS_W-1:0]              passes_i,
  output logic                                     done_o,
  output logic [gnas_pkg::HEIGHT_W-1:0]            height_out_o,
  output logic [gnas_pkg::CMD_W-1:0]               done_command_o,
  output logic                                     store_we_o,
  output logic [$clog2(GRID_SIZE*GRID_SIZE)-1:0]   store_waddr_o,
  output logic [HEIGHT_WIDTH-1:0]                  store_wdata_o,
  output logic [$clog2(GRID_SIZE*GRID_SIZE)-1:0]   store_raddr_o,
  input  logic signed [HEIGHT_WIDTH-1:0]           store_rdata_i,
  output logic [$clog2(GRID_SIZE*GRID_SIZE)-1:0]   scratch_raddr_o,
  input  logic [HEIGHT_WIDTH-1:0]                  scratch_rdata_i,
  output gnas_pkg::mean_ctl_t                      mean_ctl_o,
  output logic [$clog2(GRID_SIZE*GRID_SIZE)-1:0]   mean_addr_o
);
  import gnas_pkg::*;

  localparam int CELLS = GRID_SIZE * GRID_SIZE;
  localparam int AW    = $clog2(CELLS);
  localparam int RW    = $clog2(GRID_SIZE);
  localparam logic [AW-1:0] FIRST_PT  = AW'(GRID_SIZE + 1);
  localparam logic [AW-1:0] LAST_PT   = AW'((GRID_SIZE - 2) * GRID_SIZE + GRID_SIZE - 2);
  localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
  localparam logic [AW-1:0] ROW_STEP  = AW'(GRID_SIZE);
  localparam logic [RW-1:0] LAST_COL  = RW'(GRID_SIZE - 2);

  gnas_state_e          state_q, state_d;
  logic [AW-1:0]        pt_q, pt_d;
  logic [RW-1:0]        col_q, col_d;
  nbr_e                 nb_q, nb_d;
  logic [PASS_W-1:0]    pass_q, pass_d;
  logic                 cp_vld_q, cp_vld_d;
  logic [AW-1:0]        cp_addr_q, cp_addr_d;
  logic                 done_q, done_d;
  logic                 rd_q, rd_d;
  cmd_e                 dcmd_q, dcmd_d;
  logic [HEIGHT_W-1:0]  hout_q, hout_d;

  logic                    in_range;
  logic [AW-1:0]           in_addr;
  logic signed [HEIGHT_WIDTH-1:0] h_in;
  logic [AW-1:0]           pt_next;
  logic [RW-1:0]           col_next;

  assign in_range = (32'(row_i) < GRID_SIZE) && (32'(col_i) < GRID_SIZE);
  assign in_addr  = AW'(32'(row_i) * GRID_SIZE + 32'(col_i));
  assign h_in     = HEIGHT_WIDTH'(height_in_i);

  // step to the next interior point, skipping the two border columns
  always_comb begin
    if (col_q == LAST_COL) begin
      pt_next  = pt_q + AW'(3);
      col_next = RW'(1);
    end else begin
      pt_next  = pt_q + AW'(1);
      col_next = col_q + RW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      pt_q     <= '0;
      col_q    <= '0;
      nb_q     <= NB_NORTH;
      pass_q   <= '0;
      cp_vld_q <= 1'b0;
      done_q   <= 1'b0;
      rd_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      pt_q     <= pt_d;
      col_q    <= col_d;
      nb_q     <= nb_d;
      pass_q   <= pass_d;
      cp_vld_q <= cp_vld_d;
      done_q   <= done_d;
      rd_q     <= rd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cp_addr_q <= cp_addr_d;
    dcmd_q    <= dcmd_d;
    hout_q    <= hout_d;
  end

  always_comb begin
    state_d   = state_q;
    pt_d      = pt_q;
    col_d     = col_q;
    nb_d      = nb_q;
    pass_d    = pass_q;
    cp_vld_d  = 1'b0;
    cp_addr_d = cp_addr_q;
    done_d    = 1'b0;
    rd_d      = 1'b0;
    dcmd_d    = dcmd_q;
    hout_d    = hout_q;

    busy_o          = (state_q != ST_IDLE);
    store_we_o      = cp_vld_q;
    store_waddr_o   = cp_addr_q;
    store_wdata_o   = scratch_rdata_i;
    store_raddr_o   = in_addr;
    scratch_raddr_o = pt_q;
    mean_ctl_o      = '0;
    mean_addr_o     = pt_q;

    case (state_q)
      ST_CLEAR: begin
        store_we_o    = 1'b1;
        store_waddr_o = pt_q;
        store_wdata_o = '0;
        if (pt_q == LAST_CELL) begin
          pt_d    = '0;
          state_d = ST_IDLE;
        end else begin
          pt_d = pt_q + AW'(1);
        end
      end
      ST_IDLE: begin
        if (start_i) begin
          case (cmd_e'(command_i))
            CMD_WRITE: begin
              done_d = 1'b1;
              dcmd_d = CMD_WRITE;
              hout_d = in_range ? HEIGHT_W'(h_in) : '0;
              if (in_range) begin
                store_we_o    = 1'b1;
                store_waddr_o = in_addr;
                store_wdata_o = h_in;
              end
            end
            CMD_READ: begin
              done_d = 1'b1;
              dcmd_d = CMD_READ;
              rd_d   = in_range;
              hout_d = '0;
            end
            CMD_SMOOTH: begin
              if (passes_i == '0) begin
                done_d = 1'b1;
                dcmd_d = CMD_SMOOTH;
                hout_d = '0;
              end else begin
                state_d = ST_CALC;
                pt_d    = FIRST_PT;
                col_d   = RW'(1);
                nb_d    = NB_NORTH;
                pass_d  = '0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_CALC: begin
        mean_ctl_o.valid = 1'b1;
        mean_ctl_o.first = (nb_q == NB_NORTH);
        mean_ctl_o.last  = (nb_q == NB_EAST);
        case (nb_q)
          NB_NORTH: store_raddr_o = pt_q - ROW_STEP;
          NB_SOUTH: store_raddr_o = pt_q + ROW_STEP;
          NB_WEST:  store_raddr_o = pt_q - AW'(1);
          NB_EAST:  store_raddr_o = pt_q + AW'(1);
          default:  store_raddr_o = pt_q;
        endcase
        nb_d = nbr_e'(2'(nb_q + 2'd1));
        if (nb_q == NB_EAST) begin
          if (pt_q == LAST_PT) begin
            state_d = ST_CALC_END;
          end else begin
            pt_d  = pt_next;
            col_d = col_next;
          end
        end
      end
      ST_CALC_END: begin
        // last mean lands in scratch this cycle
        state_d = ST_COPY;
        pt_d    = FIRST_PT;
        col_d   = RW'(1);
      end
      ST_COPY: begin
        cp_vld_d  = 1'b1;
        cp_addr_d = pt_q;
        if (pt_q == LAST_PT) begin
          state_d = ST_COPY_END;
        end else begin
          pt_d  = pt_next;
          col_d = col_next;
        end
      end
      ST_COPY_END: begin
        if (PASS_W'(pass_q + PASS_W'(1)) == passes_i) begin
          done_d  = 1'b1;
          dcmd_d  = CMD_SMOOTH;
          hout_d  = '0;
          pass_d  = '0;
          pt_d    = '0;
          state_d = ST_IDLE;
        end else begin
          pass_d  = PASS_W'(pass_q + PASS_W'(1));
          pt_d    = FIRST_PT;
          col_d   = RW'(1);
          nb_d    = NB_NORTH;
          state_d = ST_CALC;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    done_o         = done_q;
    done_command_o = dcmd_q;
    height_out_o   = rd_q ? HEIGHT_W'(store_rdata_i) : hout_q;
  end

endmodule

[hdl/grid_neighbor_average_smoother.sv]
// top level: four-neighbor averaging smoother over a square height grid
// write and read: result strobed in the cycle after acceptance, one command per cycle
// smooth: per pass four store reads per point on the one store read port plus a
//   copy-back sweep; result strobed after the last pass, or with no pass for zero passes
// after reset the store is cleared with busy high
// results are one-cycle strobes on done_o; the receiver cannot stall them
module grid_neighbor_average_smoother #(
  parameter int GRID_SIZE    = 64,
  parameter int HEIGHT_WIDTH = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [gnas_pkg::CMD_W-1:0]           command_i,
  input  logic [gnas_pkg::COORD_W-1:0]         row_i,
  input  logic [gnas_pkg::COORD_W-1:0]         col_i,
  input  logic signed [gnas_pkg::HEIGHT_W-1:0] height_in_i,
  output logic                                 done_o,
  output logic signed [gnas_pkg::HEIGHT_W-1:0] height_out_o,
  output logic [gnas_pkg::CMD_W-1:0]           done_command_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [gnas_pkg::PASS_W-1:0]          cfg_data_i
);
  import gnas_pkg::*;

  localparam int CELLS = GRID_SIZE * GRID_SIZE;
  localparam int AW    = $clog2(CELLS);

  logic [PASS_W-1:0]       smooth_passes_q;

  logic                    store_we;
  logic [AW-1:0]           store_waddr, store_raddr;
  logic [HEIGHT_WIDTH-1:0] store_wdata, store_rdata;
  logic                    scratch_we;
  logic [AW-1:0]           scratch_waddr, scratch_raddr;
  logic [HEIGHT_WIDTH-1:0] scratch_wdata, scratch_rdata;
  mean_ctl_t               mean_ctl;
  logic [AW-1:0]           mean_addr;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smooth_passes_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      smooth_passes_q <= cfg_data_i;
    end
  end

  gnas_ram #(
    .WIDTH (HEIGHT_WIDTH),
    .DEPTH (CELLS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (store_waddr),
    .wdata_i (store_wdata),
    .raddr_i (store_raddr),
    .rdata_o (store_rdata)
  );

  gnas_ram #(
    .WIDTH (HEIGHT_WIDTH),
    .DEPTH (CELLS)
  ) u_scratch (
    .clk_i   (clk_i),
    .we_i    (scratch_we),
    .waddr_i (scratch_waddr),
    .wdata_i (scratch_wdata),
    .raddr_i (scratch_raddr),
    .rdata_o (scratch_rdata)
  );

  gnas_mean_unit #(
    .HEIGHT_WIDTH (HEIGHT_WIDTH),
    .ADDR_WIDTH   (AW)
  ) u_mean (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (mean_ctl),
    .addr_i  (mean_addr),
    .rdata_i (store_rdata),
    .we_o    (scratch_we),
    .waddr_o (scratch_waddr),
    .wdata_o (scratch_wdata)
  );

  gnas_ctrl #(
    .GRID_SIZE    (GRID_SIZE),
    .HEIGHT_WIDTH (HEIGHT_WIDTH)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start),
    .busy_o          (busy),
    .command_i       (command_i),
    .row_i           (row_i),
    .col_i           (col_i),
    .height_in_i     (height_in_i),
    .passes_i        (smooth_passes_q),
    .done_o          (done_o),
    .height_out_o    (height_out_o),
    .done_command_o  (done_command_o),
    .store_we_o      (store_we),
    .store_waddr_o   (store_waddr),
    .store_wdata_o   (store_wdata),
    .store_raddr_o   (store_raddr),
    .store_rdata_i   (store_rdata),
    .scratch_raddr_o (scratch_raddr),
    .scratch_rdata_i (scratch_rdata),
    .mean_ctl_o      (mean_ctl),
    .mean_addr_o     (mean_addr)
  );

endmodule

[verif/tb_top.sv]
// self-checking testbench of the grid neighbor average smoother
`timescale 1ns / 100ps

module tb_top;
  import gnas_pkg::*;

  localparam int GRID_N            = 64;
  localparam int MAX_SMOOTH_PASSES = 3;
  localparam int PASS_CYCLES       = 5 * (GRID_N - 2) * (GRID_N - 2) + 2;
  localparam int STALL_LIMIT       = 4 * MAX_SMOOTH_PASSES * PASS_CYCLES + 4 * GRID_N * GRID_N;
  localparam int PHASE_ITEMS       = 150;
  localparam int SETTLE_CYCLES     = 8;

  typedef struct {
    logic signed [HEIGHT_W-1:0] height;
    cmd_e                       cmd;
  } grid_answer_t;

  // mirror of the height grid, predicts and checks every result
  class height_grid_mirror;
    logic signed [HEIGHT_W-1:0] heights [GRID_N][GRID_N];
    logic [PASS_W-1:0]          passes;
    grid_answer_t               pending[$];
    int                         bad_results;

    function new();
      foreach (heights[i, j]) heights[i][j] = '0;
      passes      = '0;
      bad_results = 0;
    endfunction

    function void set_passes(input logic [PASS_W-1:0] value);
      passes = value;
    endfunction

    function void note_command(input cmd_e cmd, input logic [COORD_W-1:0] row,
                               input logic [COORD_W-1:0] col,
                               input logic signed [HEIGHT_W-1:0] h);
      logic signed [HEIGHT_W-1:0] next_h [GRID_N][GRID_N];
      logic signed [HEIGHT_W+1:0] sum;
      grid_answer_t               ans;
      ans.cmd    = cmd;
      ans.height = '0;
      case (cmd)
        CMD_WRITE: begin
          heights[row][col] = h;
          ans.height = h;
          pending.push_back(ans);
        end
        CMD_READ: begin
          ans.height = heights[row][col];
          pending.push_back(ans);
        end
        CMD_SMOOTH: begin
          // jacobi passes: every interior point from the old neighbors, border kept
          for (int p = 0; p < passes; p++) begin
            next_h = heights;
            for (int i = 1; i < GRID_N - 1; i++) begin
              for (int j = 1; j < GRID_N - 1; j++) begin
                sum = heights[i-1][j] + heights[i+1][j] + heights[i][j-1] + heights[i][j+1];
                next_h[i][j] = sum[HEIGHT_W+1:2];
              end
            end
            heights = next_h;
          end
          pending.push_back(ans);
        end
        default: ;
      endcase
    endfunction

    function void check_result(input logic signed [HEIGHT_W-1:0] height,
                               input logic [CMD_W-1:0] cmd);
      grid_answer_t ans;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result, height_out %0d done_command %0d",
                 $time, height, cmd);
        bad_results++;
      end else begin
        ans = pending.pop_front();
        if (height !== ans.height) begin
          $display("%0t: height_out expected %0d got %0d", $time, ans.height, height);
          bad_results++;
        end
        if (cmd !== ans.cmd) begin
          $display("%0t: done_command expected %0d got %0d", $time, ans.cmd, cmd);
          bad_results++;
        end
      end
    endfunction
  endclass

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       start = 1'b0;
  logic                       busy;
  logic [CMD_W-1:0]           command_i = '0;
  logic [COORD_W-1:0]         row_i = '0;
  logic [COORD_W-1:0]         col_i = '0;
  logic signed [HEIGHT_W-1:0] height_in_i = '0;
  logic                       done_o;
  logic signed [HEIGHT_W-1:0] height_out_o;
  logic [CMD_W-1:0]           done_command_o;
  logic                       cfg_valid_i = 1'b0;
  logic                       cfg_ready_o;
  logic [PASS_W-1:0]          cfg_data_i = '0;

  height_grid_mirror grid;
  int                quiet_cycles = 0;

  grid_neighbor_average_smoother #(
    .GRID_SIZE   (GRID_N),
    .HEIGHT_WIDTH(HEIGHT_W)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .command_i     (command_i),
    .row_i         (row_i),
    .col_i         (col_i),
    .height_in_i   (height_in_i),
    .done_o        (done_o),
    .height_out_o  (height_out_o),
    .done_command_o(done_command_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // note first, then check, so ordering inside the edge never matters
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) grid.set_passes(cfg_data_i);
      if (start && !busy) grid.note_command(cmd_e'(command_i), row_i, col_i, height_in_i);
      if (done_o) grid.check_result(height_out_o, done_command_o);
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || done_o || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic send_command(input cmd_e cmd, input logic [COORD_W-1:0] row,
                              input logic [COORD_W-1:0] col,
                              input logic signed [HEIGHT_W-1:0] h, input int gap);
    if (gap > 0) begin
      @(negedge clk_i);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    start       <= 1'b1;
    command_i   <= cmd;
    row_i       <= row;
    col_i       <= col;
    height_in_i <= h;
    do @(posedge clk_i); while (busy);
  endtask

  // hold the sender until every result is in and the block is idle
  task automatic wait_idle();
    @(negedge clk_i);
    start <= 1'b0;
    while (grid.pending.size() != 0 || busy) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_passes(input logic [PASS_W-1:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [COORD_W-1:0] pick_coord();
    case ($urandom_range(0, 3))
      0:       return COORD_W'($urandom);
      1:       return COORD_W'($urandom_range(0, 5));
      2:       return COORD_W'($urandom_range(GRID_N - 6, GRID_N - 1));
      default: return ($urandom_range(0, 1) != 0) ? COORD_W'(GRID_N - 1) : '0;
    endcase
  endfunction

  function automatic logic signed [HEIGHT_W-1:0] pick_height();
    case ($urandom_range(0, 9))
      0:       return 16'sh7fff;
      1:       return 16'sh8000;
      2:       return -16'sd1;
      3:       return 16'sd0;
      default: return HEIGHT_W'($urandom);
    endcase
  endfunction

  initial begin
    logic [PASS_W-1:0] phase_passes [9];
    int                passes_left;
    int                pick;
    int                gap;
    bit                burst;
    cmd_e              cmd;

    grid = new();
    phase_passes = '{8'd255, 8'd2, 8'd0, 8'd0, 8'd1, 8'd3, 8'd2, 8'd1, 8'd0};
    phase_passes[3] = PASS_W'($urandom_range(4, 254));
    passes_left = 30;
    burst = 1'b0;

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // store clear runs first, wait it out before touching the register
    wait_idle();
    write_passes(8'd0);

    // directed: cleared corners, extreme heights, unused command, zero and one pass
    send_command(CMD_READ,  6'd0,  6'd0,  16'sd0, 0);
    send_command(CMD_READ,  6'd63, 6'd63, 16'sd0, 0);
    send_command(CMD_WRITE, 6'd0,  6'd0,  16'sh7fff, 0);
    send_command(CMD_WRITE, 6'd63, 6'd63, 16'sh8000, 0);
    send_command(CMD_WRITE, 6'd0,  6'd63, 16'sh5555, 0);
    send_command(CMD_WRITE, 6'd63, 6'd0,  16'shaaaa, 0);
    send_command(CMD_NONE,  6'd17, 6'd42, 16'sh1234, 0);
    send_command(CMD_READ,  6'd0,  6'd0,  16'sd0, 0);
    send_command(CMD_READ,  6'd63, 6'd63, 16'sd0, 0);
    send_command(CMD_READ,  6'd0,  6'd63, 16'sd0, 0);
    send_command(CMD_READ,  6'd63, 6'd0,  16'sd0, 0);
    send_command(CMD_WRITE, 6'd1,  6'd1,  16'sh8000, 0);
    send_command(CMD_WRITE, 6'd2,  6'd2,  16'sh7fff, 0);
    send_command(CMD_WRITE, 6'd31, 6'd31, -16'sd1, 0);
    send_command(CMD_WRITE, 6'd31, 6'd33, 16'sd3, 0);
    send_command(CMD_SMOOTH, 6'd0, 6'd0,  16'sd0, 0);
    send_command(CMD_READ,  6'd1,  6'd1,  16'sd0, 0);
    wait_idle();
    write_passes(8'd1);
    send_command(CMD_SMOOTH, 6'd5, 6'd9,  16'sh7fff, 0);
    send_command(CMD_READ,  6'd1,  6'd1,  16'sd0, 0);
    send_command(CMD_READ,  6'd0,  6'd0,  16'sd0, 0);
    send_command(CMD_READ,  6'd31, 6'd32, 16'sd0, 0);
    send_command(CMD_READ,  6'd30, 6'd31, 16'sd0, 0);
    send_command(CMD_READ,  6'd1,  6'd2,  16'sd0, 0);

    // random phases, each with its own pass count; smoothing kept to a pass budget
    foreach (phase_passes[ph]) begin
      wait_idle();
      write_passes(phase_passes[ph]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 19) == 0) burst = !burst;
        gap  = burst ? 0 : $urandom_range(0, 13);
        pick = $urandom_range(0, 99);
        if (pick < 4) begin
          cmd = CMD_NONE;
        end else if (pick < 7) begin
          if (phase_passes[ph] == 0) begin
            cmd = CMD_SMOOTH;
          end else if (phase_passes[ph] <= MAX_SMOOTH_PASSES &&
                       phase_passes[ph] <= passes_left) begin
            cmd = CMD_SMOOTH;
            passes_left -= phase_passes[ph];
          end else begin
            cmd = CMD_READ;
          end
        end else if (pick < 55) begin
          cmd = CMD_WRITE;
        end else begin
          cmd = CMD_READ;
        end
        send_command(cmd, pick_coord(), pick_coord(), pick_height(), gap);
      end
    end

    wait_idle();
    if (grid.bad_results == 0 && grid.pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
